// ===== src/cdb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdb_pkg
// Types, constants and time stepping helpers for the digital clock with
// debounced set buttons.
// ----------------------------------------------------------------------------
package cdb_pkg;

   // clock time, hours wrap at 99, minutes and seconds at 59
   typedef struct packed {
      logic [6:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
   } time_type;

   // button step requests for one tick, bit1 minute button, bit0 second button
   typedef struct packed {
      logic [1:0] pick;
      logic [1:0] rep;
   } step_req_type;

   // configuration register indexes
   localparam logic [1:0] CSR_TICK_LENGTH   = 2'd0;
   localparam logic [1:0] CSR_SECOND_LENGTH = 2'd1;
   localparam logic [1:0] CSR_DEBOUNCE      = 2'd2;
   localparam logic [1:0] CSR_REPEAT        = 2'd3;

   // configuration reset values
   localparam logic [7:0]  TICK_LENGTH_RST   = 8'd33;
   localparam logic [15:0] SECOND_LENGTH_RST = 16'd1000;
   localparam logic [15:0] DEBOUNCE_RST      = 16'd30;
   localparam logic [15:0] REPEAT_RST        = 16'd500;

   // button masks
   localparam logic [1:0] BTN_NONE = 2'b00;
   localparam logic [1:0] BTN_SEC  = 2'b01;
   localparam logic [1:0] BTN_MIN  = 2'b10;
   localparam logic [1:0] BTN_BOTH = 2'b11;

   // limits
   localparam logic [10:0] MILLIS_MAX = 11'd2047;
   localparam logic [15:0] ACC_MAX    = 16'hFFFF;
   localparam logic [5:0]  SIXTY_LAST = 6'd59;
   localparam logic [6:0]  HOUR_LAST  = 7'd99;

   function automatic time_type step_hour(input time_type t);
      time_type r;
      r = t;
      r.hours = (t.hours >= HOUR_LAST) ? 7'd0 : t.hours + 7'd1;
      return r;
   endfunction

   function automatic time_type step_min(input time_type t);
      time_type r;
      r = t;
      if (t.minutes >= SIXTY_LAST) begin
         r.minutes = 6'd0;
         r = step_hour(r);
      end else begin
         r.minutes = t.minutes + 6'd1;
      end
      return r;
   endfunction

   function automatic time_type step_sec(input time_type t);
      time_type r;
      r = t;
      if (t.seconds >= SIXTY_LAST) begin
         r.seconds = 6'd0;
         r = step_min(r);
      end else begin
         r.seconds = t.seconds + 6'd1;
      end
      return r;
   endfunction

   // both buttons step hours, else minute button wins over second button
   function automatic time_type step_field(input time_type t, input logic [1:0] mask);
      time_type r;
      r = t;
      priority if (mask == BTN_BOTH) r = step_hour(t);
      else if (mask[1])             r = step_min(t);
      else if (mask[0])             r = step_sec(t);
      else                          r = t;
      return r;
   endfunction

   // saturating 16 bit accumulate of one tick length
   function automatic logic [15:0] sat_add16(input logic [15:0] acc, input logic [7:0] inc);
      logic [16:0] sum;
      sum = {1'b0, acc} + {9'd0, inc};
      return sum[16] ? ACC_MAX : sum[15:0];
   endfunction

endpackage
`default_nettype wire

// ===== src/cdb_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdb_req_if
// Tick channel carrying the two set button levels.
// ----------------------------------------------------------------------------
interface cdb_req_if;
   logic valid;
   logic ready;
   logic minute_button;
   logic second_button;

   modport source (output valid, output minute_button, output second_button, input ready);
   modport sink   (input valid, input minute_button, input second_button, output ready);
endinterface
`default_nettype wire

// ===== src/cdb_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdb_rsp_if
// Result channel carrying the time after each tick and a changed flag.
// ----------------------------------------------------------------------------
interface cdb_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] hours;
   logic [5:0] minutes;
   logic [5:0] seconds;
   logic       time_changed;

   modport source (output valid, output hours, output minutes, output seconds,
                   output time_changed, input ready);
   modport sink   (input valid, input hours, input minutes, input seconds,
                   input time_changed, output ready);
endinterface
`default_nettype wire

// ===== src/cdb_buttons.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdb_buttons
// Button sampling, debounce judging, press detection and auto-repeat.
// Gives the step requests of the current tick combinationally.
// ----------------------------------------------------------------------------
module cdb_buttons (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 tick,
   input  wire logic [1:0]           buttons,
   input  wire logic [7:0]           tick_length,
   input  wire logic [15:0]          debounce_ms,
   input  wire logic [15:0]          repeat_ms,
   output cdb_pkg::step_req_type     steps
);
   import cdb_pkg::*;

   logic        pending_ff, pending_in;
   logic [1:0]  sample_ff, sample_in;
   logic [15:0] deb_acc_ff, deb_acc_in;
   logic [1:0]  held_ff, held_in;
   logic [1:0]  rmask_ff, rmask_in;
   logic [15:0] racc_ff, racc_in;

   logic [15:0] deb_grown;
   logic [15:0] racc_grown;
   logic        judge;
   logic [1:0]  fresh;
   logic [1:0]  pick;
   logic [1:0]  rep;
   logic [1:0]  held_set;
   logic [1:0]  rmask_set;

   // judge, press detection and repeat for this tick
   always_comb begin
      deb_grown  = pending_ff ? sat_add16(deb_acc_ff, tick_length) : deb_acc_ff;
      racc_grown = (rmask_ff != BTN_NONE) ? sat_add16(racc_ff, tick_length) : racc_ff;
      judge      = pending_ff && (deb_grown > debounce_ms);
      fresh      = sample_ff & ~held_ff;

      priority if (fresh == BTN_BOTH) pick = BTN_BOTH;
      else if (fresh[1])             pick = BTN_MIN;
      else if (fresh[0])             pick = BTN_SEC;
      else                           pick = BTN_NONE;

      held_set  = held_ff | pick;
      rmask_set = (pick != BTN_NONE) ? pick : rmask_ff;

      held_in    = held_ff;
      rmask_in   = rmask_ff;
      racc_in    = racc_grown;
      rep        = BTN_NONE;
      pending_in = pending_ff;
      sample_in  = sample_ff;
      deb_acc_in = deb_grown;

      if (judge) begin
         held_in  = held_set & buttons;
         rmask_in = rmask_set;
         // a release inside the repeat mask stops auto-repeat
         if ((rmask_set & ~held_in) != BTN_NONE) begin
            rmask_in = BTN_NONE;
            racc_in  = 16'd0;
         end else if (rmask_set != BTN_NONE && racc_grown >= repeat_ms) begin
            racc_in = racc_grown - repeat_ms;
            rep     = rmask_set;
         end
      end

      // take a new sample when none is pending or the pending one was judged
      if (judge || !pending_ff) begin
         sample_in  = buttons;
         deb_acc_in = 16'd0;
         pending_in = 1'b1;
      end

      steps.pick = judge ? pick : BTN_NONE;
      steps.rep  = rep;
   end

   // button state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         sample_ff  <= BTN_NONE;
         deb_acc_ff <= 16'd0;
         held_ff    <= BTN_NONE;
         rmask_ff   <= BTN_NONE;
         racc_ff    <= 16'd0;
      end else if (tick) begin
         pending_ff <= pending_in;
         sample_ff  <= sample_in;
         deb_acc_ff <= deb_acc_in;
         held_ff    <= held_in;
         rmask_ff   <= rmask_in;
         racc_ff    <= racc_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/clock_with_debounced_set_buttons.sv =====
`timescale 1ns / 1ps
`default_nettype none
// result: an accepted tick's result is held in the output register from the next cycle
// throughput: one tick per cycle; a new tick is taken while the result waits,
// as long as the output register is empty or being drained in the same cycle
// reset: synchronous; time, accumulators and button state clear to zero,
// configuration returns to 33 ms tick, 1000 ms second, 30 ms debounce, 500 ms repeat
// ----------------------------------------------------------------------------
// clock_with_debounced_set_buttons
// Digital clock advanced by timer ticks, with debounced set buttons that step
// seconds, minutes or hours and auto-repeat while held.
// ----------------------------------------------------------------------------
module clock_with_debounced_set_buttons (
   input  wire logic        clock,
   input  wire logic        reset,
   cdb_req_if.sink          req_ch,
   cdb_rsp_if.source        rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import cdb_pkg::*;

   logic [7:0]   tick_len_ff;
   logic [15:0]  sec_len_ff;
   logic [15:0]  debounce_ff;
   logic [15:0]  repeat_ff;

   logic [10:0]  millis_ff, millis_in;
   time_type     time_ff, time_in;

   logic         rsp_valid_ff;
   time_type     rsp_time_ff;
   logic         rsp_changed_ff;

   logic         accept;
   logic [11:0]  millis_sum;
   logic [15:0]  millis_sat;
   logic [15:0]  millis_left;
   logic         sec_elapsed;
   time_type     time_a, time_b;
   logic         changed;
   step_req_type steps;

   // handshake
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   // button logic
   cdb_buttons u_buttons (
      .clock       (clock),
      .reset       (reset),
      .tick        (accept),
      .buttons     ({req_ch.minute_button, req_ch.second_button}),
      .tick_length (tick_len_ff),
      .debounce_ms (debounce_ff),
      .repeat_ms   (repeat_ff),
      .steps       (steps)
   );

   // millisecond accumulation and time update
   always_comb begin
      millis_sum  = {1'b0, millis_ff} + {4'd0, tick_len_ff};
      millis_sat  = {5'd0, (millis_sum[11] ? MILLIS_MAX : millis_sum[10:0])};
      sec_elapsed = millis_sat >= sec_len_ff;
      millis_left = millis_sat - sec_len_ff;
      millis_in   = sec_elapsed ? millis_left[10:0] : millis_sat[10:0];

      time_a  = sec_elapsed ? step_sec(time_ff) : time_ff;
      time_b  = step_field(time_a, steps.pick);
      time_in = step_field(time_b, steps.rep);
      changed = sec_elapsed || (steps.pick != BTN_NONE) || (steps.rep != BTN_NONE);
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_len_ff <= TICK_LENGTH_RST;
         sec_len_ff  <= SECOND_LENGTH_RST;
         debounce_ff <= DEBOUNCE_RST;
         repeat_ff   <= REPEAT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TICK_LENGTH:   tick_len_ff <= csr_wdata[7:0];
            CSR_SECOND_LENGTH: sec_len_ff  <= csr_wdata;
            CSR_DEBOUNCE:      debounce_ff <= csr_wdata;
            CSR_REPEAT:        repeat_ff   <= csr_wdata;
            default:           ;
         endcase
      end
   end

   // time state
   always_ff @(posedge clock) begin
      if (reset) begin
         millis_ff <= 11'd0;
         time_ff   <= '0;
      end else if (accept) begin
         millis_ff <= millis_in;
         time_ff   <= time_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_time_ff    <= time_in;
         rsp_changed_ff <= changed;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.hours        = rsp_time_ff.hours;
   assign rsp_ch.minutes      = rsp_time_ff.minutes;
   assign rsp_ch.seconds      = rsp_time_ff.seconds;
   assign rsp_ch.time_changed = rsp_changed_ff;

endmodule
`default_nettype wire
